### rtl/core/assert_macros.svh
// assertion helper macros for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain implication check on a clock with async reset
`define GPB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// check that holds also while reset is low
`define GPB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GPB_ASSERT(label, clk, rst_n, prop)
`define GPB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/core/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// types and constants shared by the gravity point blend modules
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned ONE_Q14 = 16384;

  typedef struct packed {
    logic               op;
    logic [3:0]         entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        point_radius;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } rsp_t;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLR_SUM,   // clear accumulators
    DP_OFFSET,    // form offset from table read
    DP_SHIFT,     // pick shift of magnitudes
    DP_SQ,        // squares and sum
    DP_SQRT_GO,   // start root
    DP_DIV_GO,    // start a divide, div_weight chooses operands
    DP_UNIT,      // latch unit component from divider
    DP_WEIGHT,    // compute blend distance b and b^2
    DP_LATCH_W,   // latch weight from divider
    DP_ACC,       // accumulate one component
    DP_SUM_SEL,   // load sum into offset regs for final normalize
    DP_OUT        // latch result
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] comp;     // component 0..2
    logic       div_weight; // divide for weight instead of unit
  } dp_cmd_t;

  typedef struct packed {
    logic zero_vec;   // current offset is all zero
    logic sqrt_done;
    logic div_done;
    logic w_zero;     // b too large, weight zero
  } dp_sts_t;

endpackage

### rtl/core/gravity_point_blend.sv
// ----------------------------------------------------------------------------
// gravity_point_blend
// inverse square weighted direction blend over a table of attractor points
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid_i/in_ready_o with a req_t payload. A load
// request (op 0) writes one table entry and is taken at once with no
// response; loads can follow back to back. A query request (op 1) walks the
// first point_count entries (clipped to MAX_POINTS) and returns one rsp_t on
// out_valid_o/out_ready_i. Each point runs a square root and four divides on
// the shared root and divider units; a point sitting on the query position
// is skipped. The final normalize is one root and three divides. A zero sum
// after the walk, or an empty table, answers with found low.
// The block works on one request at a time; in_ready_o is low from query
// accept until its response is taken.
// point_count is written through cfg_we_i / cfg_data_i; the user must write
// it only while idle, the block itself does not enforce this.
// Reset clears the controller and point_count; table contents stay unknown
// until loaded. A stalled receiver keeps the response held and blocks input.
// ----------------------------------------------------------------------------
module gravity_point_blend #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gpb_pkg::req_t req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gpb_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_data_i
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned IW = $clog2(MAX_POINTS + 1);

  logic [4:0] count_q;
  logic signed [31:0] q_x_q, q_y_q, q_z_q;
  gpb_pkg::dp_cmd_t cmd;
  gpb_pkg::dp_sts_t sts;
  logic [IW-1:0] idx;
  logic query;
  logic we;
  logic [31:0] tx, ty, tz, tr;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cfg_we_i) count_q <= cfg_data_i;
  end

  // query position latch
  always_ff @(posedge clk_i) begin
    if (query) begin
      q_x_q <= req_i.pos_x;
      q_y_q <= req_i.pos_y;
      q_z_q <= req_i.pos_z;
    end
  end

  assign we = in_valid_i && in_ready_o && req_i.op == gpb_pkg::OP_LOAD
           && 32'(req_i.entry_index) < MAX_POINTS;

  gpb_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_x (.clk_i(clk_i), .we_i(we),
    .waddr_i(AW'(req_i.entry_index)), .wdata_i(req_i.pos_x), .raddr_i(AW'(idx)), .rdata_o(tx));
  gpb_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_y (.clk_i(clk_i), .we_i(we),
    .waddr_i(AW'(req_i.entry_index)), .wdata_i(req_i.pos_y), .raddr_i(AW'(idx)), .rdata_o(ty));
  gpb_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_z (.clk_i(clk_i), .we_i(we),
    .waddr_i(AW'(req_i.entry_index)), .wdata_i(req_i.pos_z), .raddr_i(AW'(idx)), .rdata_o(tz));
  gpb_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_r (.clk_i(clk_i), .we_i(we),
    .waddr_i(AW'(req_i.entry_index)), .wdata_i({1'b0, req_i.point_radius}),
    .raddr_i(AW'(idx)), .rdata_o(tr));

  gpb_ctrl #(.MaxPoints(MAX_POINTS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_i, .out_valid_o, .out_ready_i,
    .count_i(count_q), .cmd_o(cmd), .sts_i(sts), .idx_o(idx), .query_o(query)
  );

  gpb_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .tab_x_i(tx), .tab_y_i(ty), .tab_z_i(tz), .tab_r_i(tr[30:0]),
    .qx_i(q_x_q), .qy_i(q_y_q), .qz_i(q_z_q), .rsp_o(rsp_o)
  );
endmodule

### rtl/core/gpb_ram.sv
// ----------------------------------------------------------------------------
// gpb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gpb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/gpb_sqrt.sv
// ----------------------------------------------------------------------------
// gpb_sqrt
// bit serial integer square root, two result bits per cycle pair
// ----------------------------------------------------------------------------
module gpb_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  // one restoring step per cycle
  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = val_i;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (rem_q >= res_q + bit_q) begin
        rem_d = rem_q - (res_q + bit_q);
        res_d = (res_q >> 1) + bit_q;
        bit_d = bit_q >> 2;
      end else begin
        res_d = res_q >> 1;
        bit_d = bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];
endmodule

### rtl/core/gpb_div.sv
// ----------------------------------------------------------------------------
// gpb_div
// radix 2 restoring divider, 64 bit dividend, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gpb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  // shift in one dividend bit and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[63:0], quo_q[63]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### rtl/core/gpb_datapath.sv
// ----------------------------------------------------------------------------
// gpb_datapath
// offset, length, unit vector, weight and sum registers of the blend
// ----------------------------------------------------------------------------
module gpb_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpb_pkg::dp_cmd_t      cmd_i,
  output gpb_pkg::dp_sts_t      sts_o,
  input  logic signed [31:0]    tab_x_i,
  input  logic signed [31:0]    tab_y_i,
  input  logic signed [31:0]    tab_z_i,
  input  logic [30:0]           tab_r_i,
  input  logic signed [31:0]    qx_i,
  input  logic signed [31:0]    qy_i,
  input  logic signed [31:0]    qz_i,
  output gpb_pkg::rsp_t         rsp_o
);
  localparam logic [63:0] WeightNum = 64'd1000000 << 36;

  // vector under work: sign and magnitude per component
  logic [2:0]  neg_q;
  logic [62:0] mag_q [3];
  logic [5:0]  sh_q;
  logic [30:0] s_q [3];
  logic [63:0] sumsq_q;
  logic [31:0] len_q;
  logic [14:0] u_q [3];
  logic [63:0] b2_q;
  logic [39:0] w_q;
  logic        wz_q;
  logic signed [63:0] acc_q [3];
  gpb_pkg::rsp_t rsp_q;

  logic        sqrt_done, div_done;
  logic [31:0] root;
  logic [63:0] quo;
  logic [63:0] div_num, div_den;
  logic [62:0] mmax;
  logic [5:0]  sh_pick;
  logic signed [34:0] dd [3];
  logic [63:0] blend_dist;
  logic signed [65:0] bb;
  logic [27:0] bcl;
  logic [14:0] uq;
  logic [54:0] prod;
  logic [1:0]  c;

  assign c = cmd_i.comp;

  // offsets from table read
  assign dd[0] = 35'(tab_x_i) - 35'(qx_i);
  assign dd[1] = 35'(tab_y_i) - 35'(qy_i);
  assign dd[2] = 35'(tab_z_i) - 35'(qz_i);

  // largest magnitude and normalizing shift (priority search on one word)
  always_comb begin
    mmax = mag_q[0];
    if (mag_q[1] > mmax) mmax = mag_q[1];
    if (mag_q[2] > mmax) mmax = mag_q[2];
    sh_pick = '0;
    for (int i = 31; i < 63; i++) begin
      if (mmax[i]) sh_pick = 6'(i - 30);
    end
  end

  // divider operands: unit component or weight
  always_comb begin
    if (cmd_i.div_weight) begin
      div_num = WeightNum;
      div_den = b2_q;
    end else begin
      div_num = ({33'd0, s_q[c]} << 14) + 64'(len_q >> 1);
      div_den = 64'(len_q);
    end
  end

  // blend distance, clamped
  assign blend_dist = 64'(len_q) << sh_q;
  assign bb   = $signed({2'b00, blend_dist}) - $signed(66'(tab_r_i));
  always_comb begin
    if (bb < 66'sd256) bcl = 28'd256;
    else bcl = bb[27:0];
  end

  assign uq   = (quo > 64'(gpb_pkg::ONE_Q14)) ? 15'(gpb_pkg::ONE_Q14) : quo[14:0];
  assign prod = 55'(u_q[c]) * 55'(w_q);

  gpb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == gpb_pkg::DP_SQRT_GO),
    .val_i   (sumsq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  gpb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == gpb_pkg::DP_DIV_GO),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // datapath registers per command
  always_ff @(posedge clk_i) begin
    if (sqrt_done) len_q <= (root == '0) ? 32'd1 : root;
    case (cmd_i.op)
      gpb_pkg::DP_CLR_SUM: begin
        for (int i = 0; i < 3; i++) acc_q[i] <= '0;
      end
      gpb_pkg::DP_OFFSET: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= dd[i][34];
          mag_q[i] <= dd[i][34] ? 63'(-dd[i]) : 63'(dd[i]);
        end
      end
      gpb_pkg::DP_SUM_SEL: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= acc_q[i][63];
          mag_q[i] <= acc_q[i][63] ? 63'(-acc_q[i]) : acc_q[i][62:0];
        end
      end
      gpb_pkg::DP_SHIFT: begin
        sh_q <= sh_pick;
        for (int i = 0; i < 3; i++) s_q[i] <= 31'(mag_q[i] >> sh_pick);
      end
      gpb_pkg::DP_SQ: begin
        sumsq_q <= 64'(s_q[0]) * 64'(s_q[0]) + 64'(s_q[1]) * 64'(s_q[1])
                 + 64'(s_q[2]) * 64'(s_q[2]);
      end
      gpb_pkg::DP_UNIT: u_q[c] <= uq;
      gpb_pkg::DP_WEIGHT: begin
        b2_q <= 64'(bcl) * 64'(bcl);
        wz_q <= (bb >= 66'sd268435456);
      end
      gpb_pkg::DP_LATCH_W: w_q <= wz_q ? '0 : quo[39:0];
      gpb_pkg::DP_ACC: begin
        acc_q[c] <= neg_q[c] ? acc_q[c] - 64'(prod) : acc_q[c] + 64'(prod);
      end
      gpb_pkg::DP_OUT: begin
        rsp_q.found <= 1'b1;
        rsp_q.dir_x <= neg_q[0] ? -16'(u_q[0]) : 16'(u_q[0]);
        rsp_q.dir_y <= neg_q[1] ? -16'(u_q[1]) : 16'(u_q[1]);
        rsp_q.dir_z <= neg_q[2] ? -16'(u_q[2]) : 16'(u_q[2]);
      end
      gpb_pkg::DP_NONE: begin
        rsp_q <= '0;
      end
      default: ;
    endcase
  end

  assign sts_o.zero_vec  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.w_zero    = wz_q;
  assign rsp_o = rsp_q;
endmodule

### rtl/core/gpb_ctrl.sv
// ----------------------------------------------------------------------------
// gpb_ctrl
// sequencer for loads, the per point walk and the final normalize
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gpb_ctrl #(
  parameter int unsigned MaxPoints = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gpb_pkg::req_t                 req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [4:0]                    count_i,
  output gpb_pkg::dp_cmd_t              cmd_o,
  input  gpb_pkg::dp_sts_t              sts_i,
  output logic [$clog2(MaxPoints+1)-1:0] idx_o,
  output logic                          query_o
);
  localparam int unsigned IW = $clog2(MaxPoints + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_READ  = 14'b00000000000100,
    S_OFS   = 14'b00000000001000,
    S_SHIFT = 14'b00000000010000,
    S_SQ    = 14'b00000000100000,
    S_SQRT  = 14'b00000001000000,
    S_UDIV  = 14'b00000010000000,
    S_WDIV  = 14'b00000100000000,
    S_ACC   = 14'b00001000000000,
    S_FIN   = 14'b00010000000000,
    S_OUT   = 14'b00100000000000,
    S_HOLD  = 14'b01000000000000,
    S_WGT   = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [IW-1:0] idx_q, idx_d, n_lim;
  logic [1:0] comp_q, comp_d;
  logic       final_q, final_d;
  logic       run_q, run_d;   // root or divider started for this step
  logic       found_q, found_d;

  // point count clipped to table depth
  assign n_lim = (32'(count_i) > MaxPoints) ? IW'(MaxPoints) : IW'(count_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    comp_d  = comp_q;
    final_d = final_q;
    run_d   = run_q;
    found_d = found_q;
    cmd_o   = '{op: gpb_pkg::DP_NONE, comp: comp_q, div_weight: 1'b0};
    cmd_o.op = gpb_pkg::DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op = gpb_pkg::DP_CLR_SUM;
        if (in_valid_i && req_i.op == gpb_pkg::OP_QUERY) begin
          idx_d   = '0;
          final_d = 1'b0;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.op = gpb_pkg::DP_CLR_SUM;
        state_d  = (idx_q < n_lim) ? S_READ : S_FIN;
      end
      S_READ: begin
        cmd_o.op = gpb_pkg::DP_CLR_SUM;
        cmd_o.op = gpb_pkg::DP_NONE;
        state_d  = S_OFS;
      end
      S_OFS: begin
        cmd_o.op = gpb_pkg::DP_OFFSET;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.zero_vec) begin
          if (final_q) begin
            state_d = S_OUT;
            found_d = 1'b0;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = (idx_q + IW'(1) < n_lim) ? S_READ : S_FIN;
          end
        end else begin
          cmd_o.op = gpb_pkg::DP_SHIFT;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = gpb_pkg::DP_SQ;
        state_d  = S_SQRT;
        run_d    = 1'b0;
      end
      S_SQRT: begin
        if (!run_q) begin
          cmd_o.op = gpb_pkg::DP_SQRT_GO;
          run_d    = 1'b1;
        end else if (sts_i.sqrt_done) begin
          run_d   = 1'b0;
          comp_d  = '0;
          state_d = S_UDIV;
        end
      end
      S_UDIV: begin
        cmd_o.comp = comp_q;
        if (!run_q) begin
          cmd_o.op = gpb_pkg::DP_DIV_GO;
          run_d    = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.op = gpb_pkg::DP_UNIT;
          run_d    = 1'b0;
          if (comp_q == 2'd2) begin
            comp_d  = '0;
            state_d = final_q ? S_OUT : S_WGT;
            found_d = 1'b1;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      S_WGT: begin
        cmd_o.op = gpb_pkg::DP_WEIGHT;
        state_d  = S_WDIV;
      end
      S_WDIV: begin
        cmd_o.div_weight = 1'b1;
        if (!run_q) begin
          cmd_o.op = gpb_pkg::DP_DIV_GO;
          run_d    = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.op = gpb_pkg::DP_LATCH_W;
          run_d    = 1'b0;
          comp_d   = '0;
          state_d  = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.op = gpb_pkg::DP_ACC;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          idx_d   = idx_q + IW'(1);
          state_d = (idx_q + IW'(1) < n_lim) ? S_READ : S_FIN;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_FIN: begin
        if (n_lim == '0) begin
          found_d = 1'b0;
          state_d = S_OUT;
        end else begin
          cmd_o.op = gpb_pkg::DP_SUM_SEL;
          final_d  = 1'b1;
          state_d  = S_SHIFT;
        end
      end
      S_OUT: begin
        cmd_o.op = found_q ? gpb_pkg::DP_OUT : gpb_pkg::DP_NONE;
        state_d  = S_HOLD;
      end
      S_HOLD: begin
        cmd_o.op = gpb_pkg::DP_CLR_SUM;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      comp_q  <= '0;
      final_q <= 1'b0;
      run_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      comp_q  <= comp_d;
      final_q <= final_d;
      run_q   <= run_d;
      found_q <= found_d;
    end
  end

  // loads are taken in idle at once, queries start the walk
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_HOLD);
  assign idx_o       = idx_q;
  assign query_o     = (state_q == S_IDLE) && in_valid_i && req_i.op == gpb_pkg::OP_QUERY;

  `GPB_ASSERT(a_out_only_hold, clk_i, rst_ni, out_valid_o |-> !in_ready_o)
  `GPB_ASSERT(a_hold_stays, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `GPB_ASSERT(a_idx_bound, clk_i, rst_ni, idx_q <= IW'(MaxPoints))
  `GPB_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// gravity_point_blend testbench
// Loads attractor points and sends blend queries through the request channel.
// A scoreboard predicts every query response in fixed point and compares each
// field. Sender gaps and receiver stalls are drawn per request.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam longint unsigned CYCLE_LIMIT = 64'd25_000_000;

  // scoreboard: own copy of the point table and the count register
  class blend_scoreboard;
    longint           pt_x[TABLE_DEPTH];
    longint           pt_y[TABLE_DEPTH];
    longint           pt_z[TABLE_DEPTH];
    longint           pt_r[TABLE_DEPTH];
    int unsigned      point_count;
    gpb_pkg::rsp_t    blend_q[$];
    int unsigned      errors;

    function new();
      point_count = 0;
      errors = 0;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
        if (v >= res + bit_pos) begin
          v = v - (res + bit_pos);
          res = (res >> 1) + bit_pos;
        end else begin
          res = res >> 1;
        end
        bit_pos = bit_pos >> 2;
      end
      return res;
    endfunction

    // unit vector of three magnitudes in Q1.14, with shift and shifted length
    function void unit_vec(input bit [2:0][63:0] mag, output int unsigned sh,
                           output bit [2:0][63:0] unit, output bit [63:0] len);
      bit [63:0] m;
      bit [63:0] sq_sum;
      bit [63:0] s;
      bit [63:0] q;
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      sh = 0;
      while ((m >> sh) >= 64'h8000_0000) sh++;
      sq_sum = 0;
      for (int k = 0; k < 3; k++) begin
        s = mag[k] >> sh;
        sq_sum += s * s;
      end
      len = int_sqrt(sq_sum);
      if (len == 0) len = 1;
      for (int k = 0; k < 3; k++) begin
        s = mag[k] >> sh;
        q = (s * gpb_pkg::ONE_Q14 + len / 2) / len;
        unit[k] = (q > gpb_pkg::ONE_Q14) ? 64'(gpb_pkg::ONE_Q14) : q;
      end
    endfunction

    function gpb_pkg::rsp_t blend(gpb_pkg::req_t r);
      longint           qp[3];
      longint           d[3];
      longint           acc[3];
      bit [2:0][63:0]   mag;
      bit [2:0][63:0]   unit;
      bit [63:0]        len;
      bit [63:0]        w;
      bit [63:0]        t;
      longint           b;
      int unsigned      sh;
      int unsigned      n;
      gpb_pkg::rsp_t    res;
      qp[0] = longint'($signed(r.pos_x));
      qp[1] = longint'($signed(r.pos_y));
      qp[2] = longint'($signed(r.pos_z));
      acc = '{0, 0, 0};
      n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
      for (int i = 0; i < n; i++) begin
        d[0] = pt_x[i] - qp[0];
        d[1] = pt_y[i] - qp[1];
        d[2] = pt_z[i] - qp[2];
        // a query sitting on the point contributes nothing
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) continue;
        for (int k = 0; k < 3; k++) mag[k] = (d[k] < 0) ? -d[k] : d[k];
        unit_vec(mag, sh, unit, len);
        b = longint'(len << sh) - pt_r[i];
        if (b < 256) b = 256;
        if (b >= (longint'(1) << 28)) w = 0;
        else w = (64'd1000000 << 36) / (64'(b) * 64'(b));
        for (int k = 0; k < 3; k++) begin
          t = unit[k] * w;
          acc[k] += (d[k] < 0) ? -longint'(t) : longint'(t);
        end
      end
      res = '0;
      if (n == 0 || (acc[0] == 0 && acc[1] == 0 && acc[2] == 0)) return res;
      for (int k = 0; k < 3; k++) mag[k] = (acc[k] < 0) ? -acc[k] : acc[k];
      unit_vec(mag, sh, unit, len);
      res.found = 1'b1;
      res.dir_x = (acc[0] < 0) ? -16'(unit[0]) : 16'(unit[0]);
      res.dir_y = (acc[1] < 0) ? -16'(unit[1]) : 16'(unit[1]);
      res.dir_z = (acc[2] < 0) ? -16'(unit[2]) : 16'(unit[2]);
      return res;
    endfunction

    function void note_request(gpb_pkg::req_t r);
      if (r.op == gpb_pkg::OP_LOAD) begin
        pt_x[r.entry_index] = longint'($signed(r.pos_x));
        pt_y[r.entry_index] = longint'($signed(r.pos_y));
        pt_z[r.entry_index] = longint'($signed(r.pos_z));
        pt_r[r.entry_index] = longint'(r.point_radius);
      end else begin
        blend_q.push_back(blend(r));
      end
    endfunction

    function void check_response(gpb_pkg::rsp_t got);
      gpb_pkg::rsp_t want;
      if (blend_q.size() == 0) begin
        $error("response with no query outstanding");
        errors++;
        return;
      end
      want = blend_q.pop_front();
      if (got.found !== want.found) begin
        $error("found expected %0d got %0d", want.found, got.found);
        errors++;
      end
      if (got.dir_x !== want.dir_x) begin
        $error("dir_x expected %0d got %0d", want.dir_x, got.dir_x);
        errors++;
      end
      if (got.dir_y !== want.dir_y) begin
        $error("dir_y expected %0d got %0d", want.dir_y, got.dir_y);
        errors++;
      end
      if (got.dir_z !== want.dir_z) begin
        $error("dir_z expected %0d got %0d", want.dir_z, got.dir_z);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  gpb_pkg::req_t req_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  gpb_pkg::rsp_t rsp_o;
  logic          cfg_we_i = 1'b0;
  logic [4:0]    cfg_data_i = '0;

  blend_scoreboard  sb = new();
  longint unsigned  cycles = 0;
  int unsigned      stall_left = 0;
  bit               quiet_sender = 1'b0;
  bit               quiet_receiver = 1'b0;

  gravity_point_blend u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gravity_point_blend verification failed");
      $finish;
    end
  end

  // receiver: check each response, then stall a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else if (out_valid_o && out_ready_i) begin
      sb.check_response(rsp_o);
      stall_left = quiet_receiver ? 0 : $urandom_range(0, 15);
      out_ready_i <= (stall_left == 0);
    end else if (!out_ready_i) begin
      if (stall_left > 0) stall_left--;
      out_ready_i <= (stall_left == 0);
    end
  end

  // one request, then the drawn gap
  task automatic send_request(gpb_pkg::req_t r);
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    gap = quiet_sender ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.blend_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(logic [4:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.point_count = v;
  endtask

  function automatic gpb_pkg::req_t make_req(logic op, logic [3:0] idx, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [30:0] rad);
    gpb_pkg::req_t r;
    r.op = op;
    r.entry_index = idx;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.point_radius = rad;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h1_0000)) - 32'sh8000);
      2: return 32'($signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
      3: return 32'($signed($urandom_range(0, 32'h400)) - 32'sh200);
      4: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return 31'($urandom());
      1: return '0;
      2: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(0, 32'h8000));
    endcase
  endfunction

  task automatic random_phase(bit hold_off);
    int unsigned   n_req;
    int unsigned   pause_at;
    int unsigned   sel;
    int unsigned   e;
    gpb_pkg::req_t r;
    // mostly small tables; sometimes empty, full or larger, up to above the table size
    sel = $urandom_range(0, 9);
    if (sel < 6) write_count(5'($urandom_range(1, 4)));
    else if (sel == 6) write_count(5'd0);
    else if (sel == 7) write_count(5'd16);
    else write_count(5'($urandom_range(5, 31)));
    quiet_sender = ($urandom_range(0, 3) == 0);
    quiet_receiver = ($urandom_range(0, 3) == 0);
    n_req = $urandom_range(20, 50);
    pause_at = hold_off ? n_req / 2 : n_req + 1;
    for (int i = 0; i < n_req; i++) begin
      if (i == pause_at) wait_drained();
      if ($urandom_range(0, 9) < 4) begin
        r = make_req(gpb_pkg::OP_LOAD, 4'($urandom()), rand_coord(), rand_coord(),
                     rand_coord(), rand_radius());
      end else if ($urandom_range(0, 4) == 0) begin
        // query sitting exactly on a loaded point
        e = $urandom_range(0, TABLE_DEPTH - 1);
        r = make_req(gpb_pkg::OP_QUERY, 4'($urandom()), 32'(sb.pt_x[e]), 32'(sb.pt_y[e]),
                     32'(sb.pt_z[e]), 31'($urandom()));
      end else begin
        r = make_req(gpb_pkg::OP_QUERY, 4'($urandom()), rand_coord(), rand_coord(),
                     rand_coord(), 31'($urandom()));
      end
      send_request(r);
    end
    wait_drained();
  endtask

  initial begin
    int unsigned phase;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table gives not found
    write_count(5'd0);
    send_request(make_req(gpb_pkg::OP_QUERY, 4'hF, '0, '0, '0, '1));
    // load the whole table, a symmetric pair first
    send_request(make_req(gpb_pkg::OP_LOAD, 4'd0, 32'd25600, '0, '0, '0));
    send_request(make_req(gpb_pkg::OP_LOAD, 4'd1, -32'sd25600, '0, '0, '0));
    send_request(make_req(gpb_pkg::OP_LOAD, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_request(make_req(gpb_pkg::OP_LOAD, 4'd3, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, '0));
    send_request(make_req(gpb_pkg::OP_LOAD, 4'd4, 32'd1, -32'sd1, '0, 31'd1));
    for (int i = 5; i < TABLE_DEPTH; i++)
      send_request(make_req(gpb_pkg::OP_LOAD, 4'(i), rand_coord(), rand_coord(),
                            rand_coord(), rand_radius()));
    wait_drained();

    // symmetric pair cancels; a query on a point skips it
    write_count(5'd2);
    send_request(make_req(gpb_pkg::OP_QUERY, '0, '0, '0, '0, '0));
    send_request(make_req(gpb_pkg::OP_QUERY, '0, 32'd25600, '0, '0, '0));
    send_request(make_req(gpb_pkg::OP_QUERY, '0, '0, 32'd256, '0, '0));
    wait_drained();

    // count above the table size, extreme positions
    write_count(5'd31);
    send_request(make_req(gpb_pkg::OP_QUERY, '0, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, '0));
    send_request(make_req(gpb_pkg::OP_QUERY, '0, 32'h7FFF_FFFF, '0, 32'h8000_0000, '0));
    send_request(make_req(gpb_pkg::OP_QUERY, '0, '0, '0, '0, '0));
    wait_drained();
    write_count(5'd16);
    send_request(make_req(gpb_pkg::OP_QUERY, '0, '1, '1, '1, '0));
    wait_drained();

    // random phases, the first pauses midway until drained
    phase = 0;
    while (phase < 25) begin
      random_phase(phase == 0 || $urandom_range(0, 3) == 0);
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.blend_q.size() == 0) begin
      $display("gravity_point_blend verification clean");
    end else begin
      $display("gravity_point_blend verification failed");
    end
    $finish;
  end

endmodule
